### rtl/core/aging_neighbor_table_unit_macros.svh
// Assertion macros shared by the neighbor table RTL.
// No dependencies; the asserting files pull this in by include.
`ifndef AGING_NEIGHBOR_TABLE_UNIT_MACROS_SVH
`define AGING_NEIGHBOR_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ANBT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ANBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ANBT_ASSERT_NOW(label, clk, rst, ante, cons)
`define ANBT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/anbt_pkg.sv
// Types and constants of the aging neighbor table.
// No dependencies; used by every module of the block.
`default_nettype none

package anbt_pkg;

   localparam int NUM_ENTRIES_DEF = 16;

   localparam int ADDR_W    = 64;
   localparam int KEY_W     = 2 * ADDR_W;
   localparam int STAMP_W   = 32;
   localparam int LEN_W     = 16;
   localparam int TIMEOUT_W = 8;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 4;
   localparam int FREED_W   = 5;

   localparam int REQ_W     = 4 * ADDR_W + LEN_W;
   localparam int RSP_W     = 16;
   localparam int RSP_PAD_W = RSP_W - STATUS_W - SLOT_W - FREED_W;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(3);
   localparam logic [LEN_W-1:0]     GOOD_LEN      = LEN_W'(16);

   localparam logic MODE_REPORT = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED = 3'd0,
      ST_ADDED   = 3'd1,
      ST_FULL    = 3'd2,
      ST_BADLEN  = 3'd3,
      ST_TICK    = 3'd4
   } status_type;

   // table write strobes from the sequencer
   typedef struct packed {
      logic parent_stamp;
      logic client;
   } mem_wr_type;

endpackage

`default_nettype wire

### rtl/core/anbt_store.sv
// Entry storage: client, parent and stamp memories, one write and one
// registered read port. Depends on anbt_pkg.
`default_nettype none

module anbt_store import anbt_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
   localparam int IDX_W = $clog2(NUM_ENTRIES)
) (
   input  wire logic               clock,
   input  wire logic [IDX_W-1:0]   rd_idx,
   input  wire mem_wr_type         wr,
   input  wire logic [IDX_W-1:0]   wr_idx,
   input  wire logic [KEY_W-1:0]   wr_client,
   input  wire logic [KEY_W-1:0]   wr_parent,
   input  wire logic [STAMP_W-1:0] wr_stamp,
   output logic      [KEY_W-1:0]   rd_client,
   output logic      [STAMP_W-1:0] rd_stamp
);

   logic [KEY_W-1:0]   client_mem [NUM_ENTRIES];
   logic [KEY_W-1:0]   parent_mem [NUM_ENTRIES];
   logic [STAMP_W-1:0] stamp_mem  [NUM_ENTRIES];

   logic [KEY_W-1:0]   rd_client_ff;
   logic [STAMP_W-1:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (wr.client) begin
         client_mem[wr_idx] <= wr_client;
      end
      if (wr.parent_stamp) begin
         parent_mem[wr_idx] <= wr_parent;
         stamp_mem[wr_idx]  <= wr_stamp;
      end
      rd_client_ff <= client_mem[rd_idx];
      rd_stamp_ff  <= stamp_mem[rd_idx];
   end

   assign rd_client = rd_client_ff;
   assign rd_stamp  = rd_stamp_ff;

endmodule

`default_nettype wire

### rtl/core/anbt_cmp.sv
// Shared compare unit: address match for reports, age check for ticks.
// Depends on anbt_pkg.
`default_nettype none

module anbt_cmp import anbt_pkg::*; (
   input  wire logic                 tick_mode,
   input  wire logic [KEY_W-1:0]     key,
   input  wire logic [KEY_W-1:0]     rd_client,
   input  wire logic [STAMP_W-1:0]   rd_stamp,
   input  wire logic [STAMP_W-1:0]   time_now,
   input  wire logic [TIMEOUT_W-1:0] timeout,
   output logic                      hit
);

   logic [STAMP_W-1:0] age;
   logic [STAMP_W-1:0] limit;

   // age wraps modulo 2^32 like the counter
   assign age   = time_now - rd_stamp;
   assign limit = {{(STAMP_W-TIMEOUT_W){1'b0}}, timeout};
   assign hit   = tick_mode ? (age >= limit) : (rd_client == key);

endmodule

`default_nettype wire

### rtl/core/anbt_seq.sv
// Scan sequencer: valid bits, time counter, per-entry scan and result register.
// Depends on anbt_pkg; drives anbt_store and reads anbt_cmp.
`default_nettype none

module anbt_seq import anbt_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
   localparam int IDX_W = $clog2(NUM_ENTRIES),
   localparam int CNT_W = $clog2(NUM_ENTRIES + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_mode,
   input  wire logic [KEY_W-1:0]   req_client,
   input  wire logic [KEY_W-1:0]   req_parent,
   input  wire logic [LEN_W-1:0]   req_len,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output status_type              rsp_status,
   output logic      [SLOT_W-1:0]  rsp_slot,
   output logic      [FREED_W-1:0] rsp_freed,
   // table and compare unit
   output logic      [IDX_W-1:0]   rd_idx,
   output mem_wr_type              wr,
   output logic      [IDX_W-1:0]   wr_idx,
   output logic      [KEY_W-1:0]   key,
   output logic      [KEY_W-1:0]   parent,
   output logic      [STAMP_W-1:0] time_now,
   output logic                    tick_mode,
   input  wire logic               hit
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    tick_ff, tick_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [KEY_W-1:0]        parent_ff, parent_in;
   logic [STAMP_W-1:0]      time_ff, time_in;
   logic [NUM_ENTRIES-1:0]  valid_ff, valid_in;
   logic                    free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   status_type              res_status_ff, res_status_in;
   logic [IDX_W-1:0]        res_idx_ff, res_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [FREED_W-1:0]      rsp_freed_ff, rsp_freed_in;

   logic                    accept;
   logic                    cur_valid;
   logic                    last;
   logic                    add_ok;
   logic [IDX_W-1:0]        add_idx;
   logic [SLOT_W+IDX_W-1:0] slot_wide;
   logic [FREED_W+CNT_W-1:0] freed_wide;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign cur_valid = valid_ff[idx_ff];
   assign last      = (idx_ff == LAST_IDX);
   // lowest free slot: an earlier one if found, else this one
   assign add_ok    = free_ok_ff || !cur_valid;
   assign add_idx   = free_ok_ff ? free_idx_ff : idx_ff;

   // slot and count are masked to the result field widths
   assign slot_wide  = {{SLOT_W{1'b0}}, res_idx_ff};
   assign freed_wide = {{FREED_W{1'b0}}, cnt_ff};

   always_comb begin
      state_in      = state_ff;
      idx_in        = '0;
      tick_in       = tick_ff;
      key_in        = key_ff;
      parent_in     = parent_ff;
      time_in       = time_ff;
      valid_in      = valid_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_freed_in  = rsp_freed_ff;
      wr            = '0;
      wr_idx        = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               tick_in     = req_mode;
               key_in      = req_client;
               parent_in   = req_parent;
               free_ok_in  = 1'b0;
               free_idx_in = '0;
               cnt_in      = '0;
               res_idx_in  = '0;
               if (req_mode == MODE_TICK) begin
                  time_in  = time_ff + STAMP_W'(1);
                  state_in = S_SCAN;
               end else if (req_len != GOOD_LEN) begin
                  res_status_in = ST_BADLEN;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            idx_in = idx_ff + IDX_W'(1);
            if (tick_ff == MODE_TICK) begin
               if (cur_valid && hit) begin
                  valid_in[idx_ff] = 1'b0;
                  cnt_in           = cnt_ff + CNT_W'(1);
               end
               if (last) begin
                  idx_in        = '0;
                  res_status_in = ST_TICK;
                  state_in      = S_RESP;
               end
            end else if (cur_valid && hit) begin
               wr.parent_stamp = 1'b1;
               idx_in          = '0;
               res_status_in   = ST_UPDATED;
               res_idx_in      = idx_ff;
               state_in        = S_RESP;
            end else begin
               if (!cur_valid && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = idx_ff;
               end
               if (last) begin
                  idx_in   = '0;
                  state_in = S_RESP;
                  if (add_ok) begin
                     wr.parent_stamp   = 1'b1;
                     wr.client         = 1'b1;
                     wr_idx            = add_idx;
                     valid_in[add_idx] = 1'b1;
                     res_status_in     = ST_ADDED;
                     res_idx_in        = add_idx;
                  end else begin
                     res_status_in = ST_FULL;
                  end
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = slot_wide[SLOT_W-1:0];
               rsp_freed_in  = freed_wide[FREED_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         time_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         time_ff      <= time_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tick_ff       <= tick_in;
      key_ff        <= key_in;
      parent_ff     <= parent_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_freed  = rsp_freed_ff;
   // read address runs one entry ahead of the compare
   assign rd_idx     = idx_in;
   assign key        = key_ff;
   assign parent     = parent_ff;
   assign time_now   = time_ff;
   assign tick_mode  = tick_ff;

endmodule

`default_nettype wire

### rtl/core/aging_neighbor_table_unit.sv
// Top level of the aging neighbor table: stream ports, timeout register,
// sequencer, compare unit and entry storage. Depends on anbt_pkg and the macros.
`default_nettype none

`include "aging_neighbor_table_unit_macros.svh"

// Learning table of NUM_ENTRIES client entries with aging. A report item
// (tuser 0) refreshes the entry whose 128-bit client address matches, or
// claims the lowest free entry, or answers table full; a payload length
// other than 16 answers bad length at once. A tick item (tuser 1) advances
// the 32-bit time and frees every entry whose age reaches timeout_ticks.
// One result per item. Reports and ticks scan the table one entry per cycle
// through a single read port and one compare unit: a tick or an unmatched
// report scans every entry before its result, a report that matches entry k
// ends the scan there, a bad length skips the scan. The block is ready for
// the next item once its result sits in the output register, even if that
// result is not yet taken. timeout_ticks may be written only while idle.

module aging_neighbor_table_unit import anbt_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request items
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // client_addr_hi, client_addr_lo, parent_addr_hi, parent_addr_lo, payload_len
   input  wire logic [REQ_W-1:0]     req_tdata,
   // mode
   input  wire logic                 req_tuser,
   // result items
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // status, slot, freed_count, zero pad
   output logic      [RSP_W-1:0]     rsp_tdata,
   // timeout_ticks write
   input  wire logic                 csr_tvalid,
   output logic                      csr_tready,
   input  wire logic [TIMEOUT_W-1:0] csr_tdata
);

   localparam int IDX_W = $clog2(NUM_ENTRIES);

   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [TIMEOUT_W-1:0] timeout_in;

   logic [KEY_W-1:0]   req_client;
   logic [KEY_W-1:0]   req_parent;
   logic [LEN_W-1:0]   req_len;

   status_type         rsp_status;
   logic [SLOT_W-1:0]  rsp_slot;
   logic [FREED_W-1:0] rsp_freed;

   logic [IDX_W-1:0]   rd_idx;
   logic [IDX_W-1:0]   wr_idx;
   mem_wr_type         wr;
   logic [KEY_W-1:0]   key;
   logic [KEY_W-1:0]   parent;
   logic [STAMP_W-1:0] time_now;
   logic               tick_mode;
   logic               hit;
   logic [KEY_W-1:0]   rd_client;
   logic [STAMP_W-1:0] rd_stamp;

   // client key is {hi, lo}; hi sits in the low tdata bits
   assign req_client = {req_tdata[ADDR_W-1:0], req_tdata[2*ADDR_W-1:ADDR_W]};
   assign req_parent = {req_tdata[3*ADDR_W-1:2*ADDR_W], req_tdata[4*ADDR_W-1:3*ADDR_W]};
   assign req_len    = req_tdata[4*ADDR_W+LEN_W-1:4*ADDR_W];

   assign csr_tready = 1'b1;
   assign timeout_in = (csr_tvalid && csr_tready) ? csr_tdata : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   anbt_seq #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (req_tuser),
      .req_client (req_client),
      .req_parent (req_parent),
      .req_len    (req_len),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot),
      .rsp_freed  (rsp_freed),
      .rd_idx     (rd_idx),
      .wr         (wr),
      .wr_idx     (wr_idx),
      .key        (key),
      .parent     (parent),
      .time_now   (time_now),
      .tick_mode  (tick_mode),
      .hit        (hit)
   );

   anbt_cmp u_cmp (
      .tick_mode (tick_mode),
      .key       (key),
      .rd_client (rd_client),
      .rd_stamp  (rd_stamp),
      .time_now  (time_now),
      .timeout   (timeout_ff),
      .hit       (hit)
   );

   anbt_store #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_store (
      .clock     (clock),
      .rd_idx    (rd_idx),
      .wr        (wr),
      .wr_idx    (wr_idx),
      .wr_client (key),
      .wr_parent (parent),
      .wr_stamp  (time_now),
      .rd_client (rd_client),
      .rd_stamp  (rd_stamp)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_freed, rsp_slot, rsp_status};

   // the sequencer is busy in the cycle after an accept
   `ANBT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // only ticks report freed entries
   `ANBT_ASSERT_NOW(a_freed_only_tick, clock, reset, rsp_tvalid && (rsp_status != ST_TICK), rsp_freed == '0)
   // slot is zero unless an entry was updated or added
   `ANBT_ASSERT_NOW(a_slot_zero, clock, reset, rsp_tvalid && (rsp_status == ST_FULL || rsp_status == ST_BADLEN || rsp_status == ST_TICK), rsp_slot == '0)

endmodule

`default_nettype wire

### bench/aging_neighbor_table_unit_tb.sv
// Self-checking bench for aging_neighbor_table_unit: directed table, then random
// reports and ticks under changing timeouts and handshake stalls.
// Depends on anbt_pkg and the block's RTL only.
`timescale 1ns / 100ps

module aging_neighbor_table_unit_tb;
   import anbt_pkg::*;

   localparam int N_ENTRIES   = NUM_ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_ITEMS  = 300;     // per random phase, three phases
   localparam int POOL_SIZE   = 24;      // more clients than slots, so the table fills
   localparam logic [ADDR_W-1:0] ONES = '1;

   typedef struct packed {
      status_type           status;
      logic [SLOT_W-1:0]    slot;
      logic [FREED_W-1:0]   freed;
   } table_rsp;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind;

   typedef struct {
      row_kind              kind;
      logic                 mode;
      logic [ADDR_W-1:0]    chi, clo, phi, plo;
      logic [LEN_W-1:0]     len;
      logic [TIMEOUT_W-1:0] tmo;
      bit                   typed;
      table_rsp             want;
   } stim_row;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 req_tuser = MODE_REPORT;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_tvalid = 1'b0;
   logic                 csr_tready;
   logic [TIMEOUT_W-1:0] csr_tdata = '0;

   // typed expectation travelling with the item on the bus
   bit                   req_typed = 1'b0;
   table_rsp             req_want;

   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   errors = 0;
   int                   cycles = 0;

   // table mirror
   bit                   mir_valid [N_ENTRIES];
   logic [ADDR_W-1:0]    mir_chi [N_ENTRIES];
   logic [ADDR_W-1:0]    mir_clo [N_ENTRIES];
   logic [ADDR_W-1:0]    mir_phi [N_ENTRIES];
   logic [ADDR_W-1:0]    mir_plo [N_ENTRIES];
   logic [STAMP_W-1:0]   mir_stamp [N_ENTRIES];
   logic [STAMP_W-1:0]   mir_now = '0;
   logic [TIMEOUT_W-1:0] mir_timeout = TIMEOUT_RESET;

   table_rsp             pending_rsp_q[$];
   stim_row              dir_rows[$];
   logic [ADDR_W-1:0]    pool_hi [POOL_SIZE];
   logic [ADDR_W-1:0]    pool_lo [POOL_SIZE];

   aging_neighbor_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mirror of the table: one result per item, from the current state.
   function automatic table_rsp lookup_or_age(logic mode, logic [ADDR_W-1:0] chi,
         logic [ADDR_W-1:0] clo, logic [ADDR_W-1:0] phi, logic [ADDR_W-1:0] plo,
         logic [LEN_W-1:0] len);
      table_rsp           r;
      int                 hit;
      int                 freed;
      logic [STAMP_W-1:0] age;
      r.status = ST_TICK;
      r.slot   = '0;
      r.freed  = '0;
      if (mode == MODE_TICK) begin
         mir_now = mir_now + 1'b1;
         freed = 0;
         for (int k = 0; k < N_ENTRIES; k++) begin
            age = mir_now - mir_stamp[k];
            if (mir_valid[k] && age >= STAMP_W'(mir_timeout)) begin
               mir_valid[k] = 1'b0;
               freed++;
            end
         end
         r.freed = FREED_W'(freed);
         return r;
      end
      r.status = ST_BADLEN;
      if (len != GOOD_LEN)
         return r;
      hit = -1;
      for (int k = 0; k < N_ENTRIES; k++)
         if (hit < 0 && mir_valid[k] && mir_chi[k] == chi && mir_clo[k] == clo)
            hit = k;
      r.status = ST_UPDATED;
      if (hit < 0) begin
         for (int k = 0; k < N_ENTRIES; k++)
            if (hit < 0 && !mir_valid[k])
               hit = k;
         r.status = ST_ADDED;
         if (hit < 0) begin
            r.status = ST_FULL;
            return r;
         end
         mir_valid[hit] = 1'b1;
         mir_chi[hit]   = chi;
         mir_clo[hit]   = clo;
      end
      mir_phi[hit]   = phi;
      mir_plo[hit]   = plo;
      mir_stamp[hit] = mir_now;
      r.slot = SLOT_W'(hit);
      return r;
   endfunction

   // Accepted items feed the mirror; accepted results are checked in order.
   always @(posedge clock) begin
      table_rsp pred;
      table_rsp got;
      table_rsp want;
      if (!reset) begin
         if (csr_tvalid && csr_tready)
            mir_timeout = csr_tdata;
         if (req_tvalid && req_tready) begin
            pred = lookup_or_age(req_tuser, req_tdata[0 +: ADDR_W],
                                 req_tdata[ADDR_W +: ADDR_W],
                                 req_tdata[2*ADDR_W +: ADDR_W],
                                 req_tdata[3*ADDR_W +: ADDR_W],
                                 req_tdata[4*ADDR_W +: LEN_W]);
            pending_rsp_q.push_back(req_typed ? req_want : pred);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[0 +: STATUS_W]);
            got.slot   = rsp_tdata[STATUS_W +: SLOT_W];
            got.freed  = rsp_tdata[STATUS_W+SLOT_W +: FREED_W];
            if (pending_rsp_q.size() == 0) begin
               $error("result with nothing pending: status %0d slot %0d freed %0d",
                      got.status, got.slot, got.freed);
               errors++;
            end else begin
               want = pending_rsp_q.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  errors++;
               end
               if (got.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, got.slot);
                  errors++;
               end
               if (got.freed !== want.freed) begin
                  $error("freed_count: expected %0d, got %0d", want.freed, got.freed);
                  errors++;
               end
            end
         end
      end
   end

   always @(negedge clock)
      rsp_tready = ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_item(logic mode, logic [ADDR_W-1:0] chi, logic [ADDR_W-1:0] clo,
         logic [ADDR_W-1:0] phi, logic [ADDR_W-1:0] plo, logic [LEN_W-1:0] len,
         bit typed, table_rsp want);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {len, plo, phi, clo, chi};
      req_typed  = typed;
      req_want   = want;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Stop sending and let every pending result drain.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_rsp_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timeout(logic [TIMEOUT_W-1:0] value);
      wait_drained();
      csr_tvalid = 1'b1;
      csr_tdata  = value;
      @(posedge clock);
      while (!csr_tready)
         @(posedge clock);
      @(negedge clock);
      csr_tvalid = 1'b0;
   endtask

   function automatic stim_row row_item(logic mode, logic [ADDR_W-1:0] chi,
         logic [ADDR_W-1:0] clo, logic [ADDR_W-1:0] phi, logic [ADDR_W-1:0] plo,
         logic [LEN_W-1:0] len, bit typed, status_type st, int slot, int freed);
      stim_row r;
      r.kind  = ROW_ITEM;
      r.mode  = mode;
      r.chi   = chi;
      r.clo   = clo;
      r.phi   = phi;
      r.plo   = plo;
      r.len   = len;
      r.tmo   = '0;
      r.typed = typed;
      r.want.status = st;
      r.want.slot   = SLOT_W'(slot);
      r.want.freed  = FREED_W'(freed);
      return r;
   endfunction

   function automatic stim_row row_csr(logic [TIMEOUT_W-1:0] value);
      stim_row r;
      r = row_item(MODE_REPORT, '0, '0, '0, '0, '0, 1'b0, ST_UPDATED, 0, 0);
      r.kind = ROW_CSR;
      r.tmo  = value;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   initial begin
      logic [ADDR_W-1:0] pat;
      logic [LEN_W-1:0]  len;
      table_rsp          none;
      int                pick;
      int                roll;
      none = '0;
      pat  = 64'h0123_4567_89AB_CDEF;

      // timeout 3 from reset; first entry is added while time is still zero
      dir_rows.push_back(row_item(MODE_REPORT, ONES, ONES, ONES, ONES, GOOD_LEN, 1,
                                  ST_ADDED, 0, 0));
      dir_rows.push_back(row_item(MODE_REPORT, '0, '0, '0, '0, GOOD_LEN, 1,
                                  ST_ADDED, 1, 0));
      dir_rows.push_back(row_item(MODE_REPORT, ONES, ONES, '0, '0, GOOD_LEN, 1,
                                  ST_UPDATED, 0, 0));
      // half matches of the 128-bit key must not hit
      dir_rows.push_back(row_item(MODE_REPORT, ONES, '0, pat, ~pat, GOOD_LEN, 1,
                                  ST_ADDED, 2, 0));
      dir_rows.push_back(row_item(MODE_REPORT, '0, ONES, ~pat, pat, GOOD_LEN, 1,
                                  ST_ADDED, 3, 0));
      dir_rows.push_back(row_item(MODE_REPORT, '0, ONES, pat, pat, GOOD_LEN, 0,
                                  ST_UPDATED, 0, 0));
      dir_rows.push_back(row_item(MODE_REPORT, ONES, ONES, ONES, ONES, 16'd0, 1,
                                  ST_BADLEN, 0, 0));
      dir_rows.push_back(row_item(MODE_REPORT, ONES, ONES, ONES, ONES, 16'hFFFF, 1,
                                  ST_BADLEN, 0, 0));
      dir_rows.push_back(row_item(MODE_REPORT, pat, pat, pat, pat, 16'd17, 1,
                                  ST_BADLEN, 0, 0));
      dir_rows.push_back(row_item(MODE_REPORT, '0, '0, '0, '0, 16'd15, 1,
                                  ST_BADLEN, 0, 0));
      dir_rows.push_back(row_item(MODE_TICK, ONES, ONES, ONES, ONES, 16'hFFFF, 1,
                                  ST_TICK, 0, 0));
      dir_rows.push_back(row_item(MODE_TICK, '0, '0, '0, '0, GOOD_LEN, 1,
                                  ST_TICK, 0, 0));
      // all four stamps reach age 3 here
      dir_rows.push_back(row_item(MODE_TICK, '0, '0, '0, '0, '0, 1, ST_TICK, 0, 4));
      // a freed entry still holds its old key but must not match
      dir_rows.push_back(row_item(MODE_REPORT, '0, '0, pat, pat, GOOD_LEN, 1,
                                  ST_ADDED, 0, 0));
      dir_rows.push_back(row_item(MODE_REPORT, ONES, ONES, ONES, ONES, GOOD_LEN, 0,
                                  ST_UPDATED, 0, 0));
      dir_rows.push_back(row_csr('0));
      dir_rows.push_back(row_item(MODE_TICK, '0, '0, '0, '0, '0, 1, ST_TICK, 0, 2));
      dir_rows.push_back(row_item(MODE_REPORT, pat, ~pat, pat, ~pat, GOOD_LEN, 0,
                                  ST_UPDATED, 0, 0));
      dir_rows.push_back(row_item(MODE_TICK, '0, '0, '0, '0, '0, 0, ST_TICK, 0, 0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct  = 38;
      recv_stall_pct = 87;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR)
            write_timeout(dir_rows[i].tmo);
         else
            send_item(dir_rows[i].mode, dir_rows[i].chi, dir_rows[i].clo, dir_rows[i].phi,
                      dir_rows[i].plo, dir_rows[i].len, dir_rows[i].typed, dir_rows[i].want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 38;
               recv_stall_pct = 87;
               write_timeout(8'd255);   // nothing ages: table fills up
            end
            1: begin
               send_idle_pct  = 87;
               recv_stall_pct = 38;
               write_timeout(8'd1);     // first tick empties a full table
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               write_timeout(TIMEOUT_W'($urandom_range(12, 2)));
            end
         endcase
         // fresh client set; some share one half of the key with a neighbor
         for (int i = 0; i < POOL_SIZE; i++) begin
            pool_hi[i] = rand64();
            pool_lo[i] = rand64();
            if (i % 4 == 3) pool_hi[i] = pool_hi[i-1];
            if (i % 4 == 2) pool_lo[i] = pool_lo[i-1];
         end
         for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2)
               wait_drained();
            roll = $urandom_range(99);
            if (roll < 12) begin
               send_item(MODE_TICK, rand64(), rand64(), rand64(), rand64(),
                         LEN_W'($urandom), 0, none);
            end else if (roll < 18) begin
               len = ($urandom_range(1) != 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(31));
               pick = $urandom_range(POOL_SIZE - 1);
               send_item(MODE_REPORT, pool_hi[pick], pool_lo[pick], rand64(), rand64(),
                         len, 0, none);
            end else if (roll < 23) begin
               send_item(MODE_REPORT, rand64(), rand64(), rand64(), rand64(), GOOD_LEN,
                         0, none);
            end else begin
               pick = $urandom_range(POOL_SIZE - 1);
               send_item(MODE_REPORT, pool_hi[pick], pool_lo[pick], rand64(), rand64(),
                         GOOD_LEN, 0, none);
            end
         end
      end

      wait_drained();
      repeat (N_ENTRIES + 8) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/anbt_pkg.sv
rtl/core/anbt_store.sv
rtl/core/anbt_cmp.sv
rtl/core/anbt_seq.sv
rtl/core/aging_neighbor_table_unit.sv
bench/aging_neighbor_table_unit_tb.sv
